// File: sv/longest_prefix_route_lookup_top_defines.svh
// ----------------------------------------------------------------------------
// longest prefix route lookup - assertion macros
// shared property shapes, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_TOP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication
`define LPRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lprl_pkg.sv
// ----------------------------------------------------------------------------
// lprl_pkg
// widths, codes, inter-cell token types and the leading-bit counter
// ----------------------------------------------------------------------------
`default_nettype none

package lprl_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned PORT_W      = 4;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned ENTRIES_DEF = 32;
  localparam int unsigned PORTS_DEF   = 16;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // table write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port;
  } wr_bus_t;

  // lookup token walking down the chain with the best match so far
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] key;
    logic [LEN_W-1:0]  best_len;
    logic [IDX_W-1:0]  best_idx;
    logic [PORT_W-1:0] best_port;
  } token_t;

  // number of leading zero bits of a 32-bit word, 32 for zero
  function automatic logic [LEN_W-1:0] lead_zeros(input logic [ADDR_W-1:0] v);
    logic [LEN_W-1:0]  n;
    logic [ADDR_W-1:0] x;
    n = '0;
    x = v;
    if (x[31:16] == 16'h0) begin
      n = n + 6'd16;
      x = {x[15:0], 16'h0};
    end
    if (x[31:24] == 8'h0) begin
      n = n + 6'd8;
      x = {x[23:0], 8'h0};
    end
    if (x[31:28] == 4'h0) begin
      n = n + 6'd4;
      x = {x[27:0], 4'h0};
    end
    if (x[31:30] == 2'h0) begin
      n = n + 6'd2;
      x = {x[29:0], 2'h0};
    end
    if (x[31] == 1'b0) begin
      n = n + 6'd1;
      x = {x[30:0], 1'b0};
    end
    if (x[31] == 1'b0) begin
      n = n + 6'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: sv/lprl_if.sv
// ----------------------------------------------------------------------------
// lprl channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lprl_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [4:0]  entry_index;
  logic [31:0] route_dest;
  logic [3:0]  entry_port;
  logic [31:0] lookup_address;

  modport source (
    output valid, operation, entry_index, route_dest, entry_port, lookup_address,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, route_dest, entry_port, lookup_address,
    output ready
  );
endinterface

interface lprl_rsp_if;
  logic       valid;
  logic       ready;
  logic       route_found;
  logic [4:0] match_index;
  logic [3:0] match_port;
  logic [5:0] match_length;

  modport source (
    output valid, route_found, match_index, match_port, match_length,
    input  ready
  );
  modport sink (
    input  valid, route_found, match_index, match_port, match_length,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/longest_prefix_route_lookup_top.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_top: one lookup at a time walks the cell chain to the result
// register, one cell a cycle unless the chain holds for a full result register
// table writes are accepted whenever no lookup is in the chain
// rst_n clears entries_in_use, the chain and the result valid flag; slots are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

`include "longest_prefix_route_lookup_top_defines.svh"

module longest_prefix_route_lookup_top import lprl_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned PORTS   = PORTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  lprl_req_if.sink              in_chan,
  lprl_rsp_if.source            out_chan
);

  localparam int unsigned       PORT_MAX_I = PORTS - 1;
  localparam logic [PORT_W-1:0] PORT_MAX   =
    (PORT_MAX_I > ((1 << PORT_W) - 1)) ? '1 : PORT_W'(PORT_MAX_I);

  logic [CNT_W-1:0]  entries_r;
  logic [CNT_W-1:0]  entries_nxt;
  logic              in_flight_r;
  logic              in_flight_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_found_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [PORT_W-1:0] out_port_r;
  logic [LEN_W-1:0]  out_len_r;

  logic    in_fire;
  logic    lookup_fire;
  logic    advance;
  logic    move;
  wr_bus_t wr;
  token_t  tok [0:ENTRIES];
  token_t  tail;

  assign in_chan.ready = !in_flight_r;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign lookup_fire   = in_fire && (in_chan.operation == OP_LOOKUP);

  // write word, port clamped to the highest configured port
  always_comb begin
    wr.en      = in_fire && (in_chan.operation == OP_WRITE);
    wr.index   = in_chan.entry_index;
    wr.address = in_chan.route_dest;
    wr.port    = (32'(in_chan.entry_port) > PORT_MAX_I) ? PORT_MAX : in_chan.entry_port;
  end

  always_comb begin
    tok[0].valid     = lookup_fire;
    tok[0].key       = in_chan.lookup_address;
    tok[0].best_len  = '0;
    tok[0].best_idx  = '0;
    tok[0].best_port = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lprl_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .advance        (advance),
      .entries_in_use (entries_r),
      .wr             (wr),
      .tok_in         (tok[i]),
      .tok_out        (tok[i+1])
    );
  end

  assign tail = tok[ENTRIES];

  // chain holds while a finished word waits behind a full result register
  assign advance = !(tail.valid && out_valid_r && !out_chan.ready);
  assign move    = tail.valid && advance;

  always_comb begin
    entries_nxt   = cfg_we ? cfg_wdata : entries_r;
    in_flight_nxt = in_flight_r;
    if (lookup_fire) begin
      in_flight_nxt = 1'b1;
    end else if (move) begin
      in_flight_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= '0;
      in_flight_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      entries_r   <= entries_nxt;
      in_flight_r <= in_flight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_found_r <= (tail.best_len != '0);
      out_idx_r   <= tail.best_idx;
      out_port_r  <= tail.best_port;
      out_len_r   <= tail.best_len;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.route_found  = out_found_r;
  assign out_chan.match_index  = out_idx_r;
  assign out_chan.match_port   = out_port_r;
  assign out_chan.match_length = out_len_r;

  `LPRL_ASSERT_IMP(a_tail_owned, tail.valid, in_flight_r, "lookup word in chain without owner")
  `LPRL_ASSERT_NXT(a_lookup_tracked, lookup_fire, in_flight_r, "accepted lookup not tracked")
  `LPRL_ASSERT_NXT(a_tail_holds, tail.valid && !advance,
    tail.valid && $stable(tail.best_len), "stalled lookup word lost")
  `LPRL_ASSERT_IMP(a_found_len, out_valid_r, out_found_r == (out_len_r != '0),
    "route flag disagrees with match length")
  `LPRL_ASSERT_IMP(a_no_route_zero, out_valid_r && !out_found_r,
    (out_idx_r == '0) && (out_port_r == '0), "no-route result carries slot data")

endmodule

`default_nettype wire

// File: sv/lprl_cell.sv
// ----------------------------------------------------------------------------
// lprl_cell
// one route slot: stores address and port, scores the passing lookup word
// ----------------------------------------------------------------------------
`default_nettype none

module lprl_cell import lprl_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic [CNT_W-1:0] entries_in_use,
  input  wire wr_bus_t          wr,
  input  wire token_t           tok_in,
  output token_t                tok_out
);

  localparam bit               WRITABLE  = (CELL_IDX < (1 << IDX_W));
  localparam logic [IDX_W-1:0] CELL_SLOT = IDX_W'(CELL_IDX);

  logic [ADDR_W-1:0] addr_r;
  logic [PORT_W-1:0] port_r;
  token_t            tok_r;
  token_t            tok_nxt;
  logic              active;
  logic [LEN_W-1:0]  shared;

  always_ff @(posedge clk) begin
    if (WRITABLE && wr.en && (wr.index == CELL_SLOT)) begin
      addr_r <= wr.address;
      port_r <= wr.port;
    end
  end

  assign active = (CELL_IDX < 32'(entries_in_use));
  assign shared = lead_zeros(addr_r ^ tok_in.key);

  // strict compare keeps the earlier slot on a tie
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && active && (shared > tok_in.best_len)) begin
      tok_nxt.best_len  = shared;
      tok_nxt.best_idx  = CELL_SLOT;
      tok_nxt.best_port = port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (advance) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: sim/longest_prefix_route_lookup_top_tb.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_top_tb
// drives table writes and address lookups through the request channel,
// predicts each lookup's longest-prefix route from a local table copy and
// checks every response word in order, with random gaps on both channels
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_top_tb;
  import lprl_pkg::*;

  localparam int unsigned ROUTES        = ENTRIES_DEF;
  localparam int unsigned SETTLE_CYCLES = ROUTES + 8;
  localparam int unsigned RANDOM_WORDS  = 240;
  localparam int unsigned MAX_PRINTS    = 50;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  length;
  } route_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  lprl_req_if in_if ();
  lprl_rsp_if out_if ();

  longest_prefix_route_lookup_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // local copy of the routing table and the lookup range
  logic [ADDR_W-1:0] route_addr [ROUTES];
  logic [PORT_W-1:0] route_port [ROUTES];
  int unsigned       active_routes = 0;

  route_result_t pending_routes [$];
  int unsigned   mismatch_count = 0;
  bit            idle_en = 1'b0;
  int unsigned   ready_hold = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [LEN_W-1:0] shared_prefix(input logic [ADDR_W-1:0] a,
                                                     input logic [ADDR_W-1:0] b);
    logic [ADDR_W-1:0] diff;
    logic [LEN_W-1:0]  n;
    bit                stop;
    diff = a ^ b;
    n    = '0;
    stop = 1'b0;
    for (int pos = ADDR_W - 1; pos >= 0; pos--) begin
      if (!stop) begin
        if (diff[pos]) stop = 1'b1;
        else n++;
      end
    end
    return n;
  endfunction

  // earliest slot wins a tie since only a strictly longer prefix replaces it
  function automatic route_result_t predict_lookup(input logic [ADDR_W-1:0] dst);
    route_result_t    best;
    logic [LEN_W-1:0] n;
    best = '0;
    for (int i = 0; i < active_routes; i++) begin
      n = shared_prefix(route_addr[i], dst);
      if (n > best.length) begin
        best.found  = 1'b1;
        best.index  = i[IDX_W-1:0];
        best.port   = route_port[i];
        best.length = n;
      end
    end
    return best;
  endfunction

  // address sharing a random number of leading bits with one of the first lim slots
  function automatic logic [ADDR_W-1:0] near_address(input int unsigned lim);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] low_mask;
    logic [ADDR_W-1:0] flip;
    int unsigned       keep;
    base = route_addr[$urandom_range(0, lim - 1)];
    keep = $urandom_range(0, ADDR_W);
    if (keep == ADDR_W) return base;
    flip     = 32'h8000_0000 >> keep;
    low_mask = 32'hFFFF_FFFF >> (keep + 1);
    return ((base ^ flip) & ~low_mask) | ($urandom() & low_mask);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  task automatic send_word(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [ADDR_W-1:0] addr, input logic [PORT_W-1:0] port,
                           input logic [ADDR_W-1:0] dst);
    in_if.valid          <= 1'b1;
    in_if.operation      <= op;
    in_if.entry_index    <= idx;
    in_if.route_dest     <= addr;
    in_if.entry_port     <= port;
    in_if.lookup_address <= dst;
    do @(posedge clk); while (!in_if.ready);
    if (op == OP_WRITE) begin
      route_addr[idx] = addr;
      route_port[idx] = port;
    end else begin
      pending_routes.push_back(predict_lookup(dst));
    end
  endtask

  task automatic write_route(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] addr,
                             input logic [PORT_W-1:0] port);
    send_word(OP_WRITE, idx, addr, port, $urandom());
  endtask

  // entry fields carry noise, the block must ignore them
  task automatic lookup_route(input logic [ADDR_W-1:0] dst);
    send_word(OP_LOOKUP, IDX_W'($urandom_range(0, ROUTES - 1)), $urandom(),
              PORT_W'($urandom_range(0, 15)), dst);
  endtask

  task automatic maybe_pause();
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // writes leave no response, so allow the chain to settle after the last one
  task automatic drain_lookups();
    in_if.valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_routes(input logic [CNT_W-1:0] value);
    drain_lookups();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_routes = (32'(value) > ROUTES) ? ROUTES : 32'(value);
  endtask

  task automatic test_empty_table();
    set_active_routes('0);
    lookup_route(32'h0000_0000);
    lookup_route(32'hFFFF_FFFF);
    lookup_route($urandom());
  endtask

  task automatic test_single_route();
    write_route(5'd0, 32'h0000_0000, 4'd0);
    set_active_routes(6'd1);
    lookup_route(32'h0000_0000);
    lookup_route(32'h8000_0000);
    lookup_route(32'h0000_0001);
    lookup_route(32'h7FFF_FFFF);
  endtask

  task automatic test_tie_break();
    write_route(5'd1, 32'hFFFF_FFFF, 4'd15);
    write_route(5'd2, 32'hFFFF_0000, 4'd5);
    write_route(5'd3, 32'hFFFF_0000, 4'd9);
    set_active_routes(6'd4);
    lookup_route(32'hFFFF_0000);
    lookup_route(32'hFFFE_0000);
    lookup_route(32'hFFFF_FFFF);
    lookup_route(32'h0000_0000);
  endtask

  task automatic test_fill_table();
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < ROUTES; i++) begin
      maybe_pause();
      addr = (i > 0 && $urandom_range(0, 1)) ? near_address(i) : $urandom();
      write_route(i[IDX_W-1:0], addr, PORT_W'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_random_traffic(input logic [CNT_W-1:0] cfg_value,
                                     input int unsigned words, input bit idle);
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] addr;
    int unsigned       sel;
    set_active_routes(cfg_value);
    idle_en = idle;
    for (int unsigned n = 0; n < words; n++) begin
      // sender holds off halfway through each phase until every lookup has answered
      if (n == words / 2) drain_lookups();
      maybe_pause();
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        addr = $urandom_range(0, 1) ? $urandom() : near_address(ROUTES);
        write_route(IDX_W'($urandom_range(0, ROUTES - 1)), addr,
                    PORT_W'($urandom_range(0, 15)));
      end else begin
        if (active_routes == 0 || sel == 2) dst = $urandom();
        else if (sel == 3) dst = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        else dst = near_address(active_routes);
        lookup_route(dst);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold != 0) begin
      out_if.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 7);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_word
    route_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_routes.size() == 0) begin
        report_mismatch("response word with no lookup pending");
      end else begin
        want = pending_routes.pop_front();
        check_field("route_found", 32'(want.found), 32'(out_if.route_found));
        check_field("match_index", 32'(want.index), 32'(out_if.match_index));
        check_field("match_port", 32'(want.port), 32'(out_if.match_port));
        check_field("match_length", 32'(want.length), 32'(out_if.match_length));
      end
    end
  end

  initial begin
    in_if.valid          <= 1'b0;
    in_if.operation      <= OP_WRITE;
    in_if.entry_index    <= '0;
    in_if.route_dest     <= '0;
    in_if.entry_port     <= '0;
    in_if.lookup_address <= '0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    rst_n                <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    idle_en = 1'b1;

    test_empty_table();
    test_single_route();
    test_tie_break();
    test_fill_table();
    test_random_traffic(6'd32, RANDOM_WORDS, 1'b1);
    test_random_traffic(6'd63, RANDOM_WORDS, 1'b1);
    test_random_traffic(6'd1, RANDOM_WORDS, 1'b1);
    test_random_traffic(6'd20, RANDOM_WORDS, 1'b0);
    test_random_traffic(6'd33, RANDOM_WORDS, 1'b1);
    test_random_traffic(6'd0, 60, 1'b1);
    test_random_traffic(CNT_W'($urandom_range(2, 31)), RANDOM_WORDS, 1'b1);
    test_random_traffic(6'd32, RANDOM_WORDS, 1'b0);
    drain_lookups();

    if (mismatch_count == 0) begin
      $display("** longest_prefix_route_lookup_top: PASSED **");
    end else begin
      $display("** longest_prefix_route_lookup_top: FAILED **");
    end
    $finish;
  end

  // worst case is far below this: about 2000 words in all
  initial begin
    #6000000;
    $display("** longest_prefix_route_lookup_top: FAILED **");
    $finish;
  end

endmodule
